FILE: design/idlt_pkg.sv
package idlt_pkg;

  typedef enum logic [1:0] {
    CMD_ID_OF_OBJ = 2'd0,
    CMD_OBJ_OF_ID = 2'd1,
    CMD_LINK      = 2'd2,
    CMD_UNLINK    = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [2:0] ST_OBJ_LINKED  = 3'd2;
  localparam logic [2:0] ST_ID_IN_USE   = 3'd3;
  localparam logic [2:0] ST_NO_FREE_ID  = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_READ  = 2'd2,
    S_CHECK = 2'd3
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/id_link_table_with_free_list_core.sv
// ID link table with free-ID list.
// Input channel (in_valid/in_ready) carries one command per transaction:
// lookup ID of object, lookup object of ID, link (explicit or auto-assigned
// ID) and unlink. Output channel (out_valid/out_ready) returns exactly one
// result transaction per command: status, found_object, found_id.
// Steps: each command is accepted, reads the object-to-ID table, then
// reads the ID-to-object table at an address taken from the first read,
// with decision and writeback. Because of this chained read, a new command
// is accepted only after the current one has been written back.
// The result sits in an output register; a new command is accepted while it
// waits. If the receiver stalls, the next command holds at writeback until
// the output register frees up.
// Reset: synchronous, active high. After reset the block runs a clearing
// pass over every slot (both tables invalidated, free list loaded with
// 0..NUM_SLOTS-1) with in_ready low.
module id_link_table_with_free_list_core #(
  parameter int NUM_SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] object_num,
  input  logic [7:0] net_id,
  input  logic       auto_assign,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] found_object,
  output logic [7:0] found_id
);

  idlt_pkg::ctrl_t ctrl;
  idlt_pkg::stat_t stat;

  idlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  idlt_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cmd          (cmd),
    .object_num   (object_num),
    .net_id       (net_id),
    .auto_assign  (auto_assign),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_object (found_object),
    .found_id     (found_id)
  );

  a_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.clear_step, ctrl.load, ctrl.commit}))
    else $error("controller commands overlap");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> out_valid)
    else $error("result not presented after commit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command accepted while one is in flight");

  a_no_commit_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !ctrl.commit)
    else $error("result register overwritten while stalled");

endmodule

FILE: design/idlt_ram.sv
module idlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/idlt_ctrl.sv
module idlt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  idlt_pkg::stat_t  stat,
  output idlt_pkg::ctrl_t  ctrl
);

  idlt_pkg::state_t state;
  idlt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idlt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      idlt_pkg::S_CLEAR: begin
        if (stat.clear_last) state_next = idlt_pkg::S_IDLE;
      end
      idlt_pkg::S_IDLE: begin
        if (in_valid) state_next = idlt_pkg::S_READ;
      end
      idlt_pkg::S_READ: begin
        state_next = idlt_pkg::S_CHECK;
      end
      idlt_pkg::S_CHECK: begin
        if (stat.out_free) state_next = idlt_pkg::S_IDLE;
      end
      default: begin
        state_next = idlt_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    ctrl.clear_step = 1'b0;
    ctrl.load       = 1'b0;
    ctrl.commit     = 1'b0;
    case (state)
      idlt_pkg::S_CLEAR: begin
        ctrl.clear_step = 1'b1;
      end
      idlt_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      idlt_pkg::S_CHECK: begin
        ctrl.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/idlt_datapath.sv
module idlt_datapath #(
  parameter int NUM_SLOTS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  idlt_pkg::ctrl_t  ctrl,
  output idlt_pkg::stat_t  stat,
  input  logic [1:0]       cmd,
  input  logic [7:0]       object_num,
  input  logic [7:0]       net_id,
  input  logic             auto_assign,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic [7:0]       found_object,
  output logic [7:0]       found_id
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  idlt_pkg::cmd_t cmd_q;
  logic [7:0]     obj_q;
  logic [7:0]     nid_q;
  logic           auto_q;

  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [CW-1:0] count;
  logic [IW-1:0] clr_idx;

  logic          o2i_we;
  logic [IW-1:0] o2i_waddr;
  logic [IW:0]   o2i_wdata;
  logic [IW-1:0] o2i_raddr;
  logic [IW:0]   o2i_rdata;

  logic          i2o_we;
  logic [IW-1:0] i2o_waddr;
  logic [8:0]    i2o_wdata;
  logic [8:0]    i2o_rdata;

  logic          fifo_we;
  logic [IW-1:0] fifo_waddr;
  logic [IW-1:0] fifo_wdata;
  logic [IW-1:0] fifo_rdata;

  logic          obj_ok;
  logic          id_ok;
  logic          o2i_hit;
  logic [IW-1:0] o2i_id;
  logic          i2o_hit;
  logic [IW-1:0] id_sel;
  logic          fifo_full;
  logic          fifo_empty;

  logic [2:0]    res_status;
  logic [7:0]    res_obj;
  logic [7:0]    res_id;
  logic          do_link;
  logic          do_unlink;
  logic          do_pop;
  logic          do_push;

  assign obj_ok     = 32'(obj_q) < NUM_SLOTS;
  assign id_ok      = 32'(nid_q) < NUM_SLOTS;
  assign o2i_hit    = o2i_rdata[IW];
  assign o2i_id     = o2i_rdata[IW-1:0];
  assign i2o_hit    = i2o_rdata[8];
  assign fifo_full  = count == CW'(NUM_SLOTS);
  assign fifo_empty = count == '0;

  assign stat.clear_last = clr_idx == IW'(NUM_SLOTS - 1);
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    case (cmd_q)
      idlt_pkg::CMD_LINK:   id_sel = auto_q ? fifo_rdata : IW'(nid_q);
      idlt_pkg::CMD_UNLINK: id_sel = o2i_id;
      default:              id_sel = IW'(nid_q);
    endcase
  end

  always_comb begin
    res_status = idlt_pkg::ST_NOT_FOUND;
    res_obj    = '0;
    res_id     = '0;
    do_link    = 1'b0;
    do_unlink  = 1'b0;
    do_pop     = 1'b0;
    case (cmd_q)
      idlt_pkg::CMD_ID_OF_OBJ: begin
        if (obj_ok && o2i_hit) begin
          res_status = idlt_pkg::ST_OK;
          res_id     = 8'(o2i_id);
        end
      end
      idlt_pkg::CMD_OBJ_OF_ID: begin
        if (id_ok && i2o_hit) begin
          res_status = idlt_pkg::ST_OK;
          res_obj    = i2o_rdata[7:0];
        end
      end
      idlt_pkg::CMD_LINK: begin
        if (!obj_ok) begin
          res_status = idlt_pkg::ST_NOT_FOUND;
        end else if (o2i_hit) begin
          res_status = idlt_pkg::ST_OBJ_LINKED;
        end else if (auto_q && fifo_empty) begin
          res_status = idlt_pkg::ST_NO_FREE_ID;
        end else if (!auto_q && !id_ok) begin
          res_status = idlt_pkg::ST_NOT_FOUND;
        end else begin
          do_pop = auto_q;
          if (i2o_hit) begin
            res_status = idlt_pkg::ST_ID_IN_USE;
          end else begin
            res_status = idlt_pkg::ST_OK;
            res_id     = 8'(id_sel);
            do_link    = 1'b1;
          end
        end
      end
      idlt_pkg::CMD_UNLINK: begin
        if (obj_ok && o2i_hit) begin
          res_status = idlt_pkg::ST_OK;
          do_unlink  = 1'b1;
        end
      end
      default: begin
        res_status = idlt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  assign do_push = do_unlink && !fifo_full;

  // table ports: clear pass first, then command writeback
  assign o2i_raddr  = ctrl.load ? IW'(object_num) : IW'(obj_q);
  assign o2i_we     = ctrl.clear_step || (ctrl.commit && (do_link || do_unlink));
  assign o2i_waddr  = ctrl.clear_step ? clr_idx : IW'(obj_q);
  assign o2i_wdata  = (!ctrl.clear_step && do_link) ? {1'b1, id_sel} : '0;

  assign i2o_we     = ctrl.clear_step || (ctrl.commit && (do_link || do_unlink));
  assign i2o_waddr  = ctrl.clear_step ? clr_idx : id_sel;
  assign i2o_wdata  = (!ctrl.clear_step && do_link) ? {1'b1, obj_q} : '0;

  assign fifo_we    = ctrl.clear_step || (ctrl.commit && do_push);
  assign fifo_waddr = ctrl.clear_step ? clr_idx : tail;
  assign fifo_wdata = ctrl.clear_step ? clr_idx : id_sel;

  idlt_ram #(.WIDTH(IW + 1), .DEPTH(NUM_SLOTS)) u_o2i (
    .clk   (clk),
    .we    (o2i_we),
    .waddr (o2i_waddr),
    .wdata (o2i_wdata),
    .raddr (o2i_raddr),
    .rdata (o2i_rdata)
  );

  idlt_ram #(.WIDTH(9), .DEPTH(NUM_SLOTS)) u_i2o (
    .clk   (clk),
    .we    (i2o_we),
    .waddr (i2o_waddr),
    .wdata (i2o_wdata),
    .raddr (id_sel),
    .rdata (i2o_rdata)
  );

  idlt_ram #(.WIDTH(IW), .DEPTH(NUM_SLOTS)) u_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= idlt_pkg::cmd_t'(cmd);
      obj_q  <= object_num;
      nid_q  <= net_id;
      auto_q <= auto_assign;
    end
    if (ctrl.commit) begin
      status       <= res_status;
      found_object <= res_obj;
      found_id     <= res_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= CW'(NUM_SLOTS);
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.clear_step) begin
        clr_idx <= stat.clear_last ? '0 : clr_idx + IW'(1);
      end
      if (ctrl.commit && do_pop) begin
        head  <= (head == IW'(NUM_SLOTS - 1)) ? '0 : head + IW'(1);
        count <= count - CW'(1);
      end
      if (ctrl.commit && do_push) begin
        tail  <= (tail == IW'(NUM_SLOTS - 1)) ? '0 : tail + IW'(1);
        count <= count + CW'(1);
      end
      if (ctrl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
